// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// An implication checked in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/stunbr_pkg.sv -----
// ----------------------------------------------------------------------------
// stunbr_pkg
// Types and constants of the STUN binding request parser.
// ----------------------------------------------------------------------------
`default_nettype none

package stunbr_pkg;

   localparam logic [31:0] COOKIE        = 32'h2112a442;
   localparam logic [31:0] FP_XOR        = 32'h5354554e;
   localparam logic [31:0] CRC_POLY      = 32'hedb88320;
   localparam logic [15:0] T_BINDING     = 16'h0001;
   localparam logic [15:0] T_USERNAME    = 16'h0006;
   localparam logic [15:0] T_INTEGRITY   = 16'h0008;
   localparam logic [15:0] T_ERROR_CODE  = 16'h0009;
   localparam logic [15:0] T_UNKNOWN_ATT = 16'h000a;
   localparam logic [15:0] T_XOR_MAPPED  = 16'h0020;
   localparam logic [15:0] T_PRIORITY    = 16'h0024;
   localparam logic [15:0] T_USE_CAND    = 16'h0025;
   localparam logic [15:0] T_FINGERPRINT = 16'h8028;
   localparam logic [15:0] T_CONTROLLED  = 16'h8029;
   localparam logic [15:0] T_CONTROLLING = 16'h802a;
   localparam logic [15:0] TOP_BITS      = 16'hc000;
   localparam logic [15:0] REQUIRED_LIM  = 16'h8000;

   // Bit positions in the seen-attribute flags.
   localparam int F_USER    = 0;
   localparam int F_INTEG   = 1;
   localparam int F_PRIO    = 2;
   localparam int F_USECAND = 3;
   localparam int F_CTRLING = 4;
   localparam int F_CTRLED  = 5;
   localparam int F_FP      = 6;
   localparam int F_UOVF    = 7;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_ATTR_HDR,
      PH_VALUE,
      PH_PAD,
      PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_HEADER      = 4'd1,
      ST_TYPE        = 4'd2,
      ST_LENGTH      = 4'd3,
      ST_OVERFLOW    = 4'd4,
      ST_BAD_ATTR    = 4'd5,
      ST_TRAILING    = 4'd6,
      ST_NO_USERNAME = 4'd7,
      ST_NO_INTEG    = 4'd8,
      ST_FP_PLACE    = 4'd9,
      ST_CRC         = 4'd10,
      ST_TOO_LONG    = 4'd11
   } status_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] attribute_type;
      logic        final_result;
      status_type  status;
      logic        has_priority;
      logic        has_use_candidate;
      logic        has_ice_controlling;
      logic        has_ice_controlled;
      logic [10:0] username_offset;
      logic [10:0] username_length;
      logic [10:0] integrity_offset;
      logic        unknown_overflow;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/core/stun_binding_request_parser_top.sv -----
// ----------------------------------------------------------------------------
// stun_binding_request_parser_top
// Byte-wide STUN binding request checker with ICE attribute summary.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle on the req_ channel while
// req_ready is high, with req_last_byte marking the final byte, and checks
// the STUN header, walks the attributes and verifies the FINGERPRINT CRC on
// the fly. Each byte is parsed in the cycle in which its transaction
// completes, so the input side then sustains one byte per clock. Nothing is
// produced for the inner bytes of a packet. On the last byte, a good packet
// yields one kind 0 transaction per stored comprehension-required unknown
// attribute type, in arrival order, followed by the summary; a failed
// packet yields the summary alone, with its flags and offsets zero. With no
// unknown entries, the summary leaves through the output register in the
// cycle after the last byte, and the next packet may start at once. Unknown
// entries are read one per cycle while the output register is free, from a
// small store with a registered read port, and req_ready stays low until
// the summary has been loaded. A waiting result blocks the input: the next
// byte is taken in the same cycle in which the output register is emptied.
// No clearing pass is run after reset. Username comparison and the HMAC
// check are left to software, which is given the offsets it needs.
// ----------------------------------------------------------------------------
`default_nettype none

module stun_binding_request_parser_top #(
   parameter int MAX_BYTES   = 2048,
   parameter int MAX_UNKNOWN = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [15:0]      rsp_attribute_type,
   output logic             rsp_final_result,
   output logic [3:0]       rsp_status,
   output logic             rsp_has_priority,
   output logic             rsp_has_use_candidate,
   output logic             rsp_has_ice_controlling,
   output logic             rsp_has_ice_controlled,
   output logic [10:0]      rsp_username_offset,
   output logic [10:0]      rsp_username_length,
   output logic [10:0]      rsp_integrity_offset,
   output logic             rsp_unknown_overflow
);

   // Byte position saturates at MAX_BYTES+1; attribute arithmetic needs room
   // for an offset plus a full 16-bit length.
   localparam int PW  = $clog2(MAX_BYTES + 2);
   localparam int AW  = ((PW > 17) ? PW : 17) + 1;
   localparam int CW  = $clog2(MAX_UNKNOWN + 1);
   localparam int UIW = (MAX_UNKNOWN > 1) ? $clog2(MAX_UNKNOWN) : 1;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? stunbr_pkg::CRC_POLY : 32'd0);
      end
      return c;
   endfunction

   // Phase after the last byte of an attribute value or its padding.
   function automatic stunbr_pkg::phase_type next_phase(input logic [PW-1:0] p,
                                                        input logic [AW-1:0] fin);
      logic [AW-1:0] q;
      q = AW'(p) + AW'(1);
      if (q[1:0] != 2'd0) begin
         return stunbr_pkg::PH_PAD;
      end else if (q == fin) begin
         return stunbr_pkg::PH_DONE;
      end else begin
         return stunbr_pkg::PH_ATTR_HDR;
      end
   endfunction

   // Parse state.
   logic [PW-1:0]           pos_ff, pos_in;
   stunbr_pkg::phase_type   phase_ff, phase_in;
   logic [31:0]             shift_ff, shift_in;
   logic [15:0]             declared_ff, declared_in;
   logic [15:0]             atype_ff, atype_in;
   logic [15:0]             rem_ff, rem_in;
   logic [7:0]              flags_ff, flags_in;
   stunbr_pkg::status_type  sticky_ff, sticky_in;
   logic [31:0]             crc_ff, crc_in;
   logic [31:0]             snap_ff, snap_in;
   logic [31:0]             fpword_ff, fpword_in;
   logic [PW-1:0]           fpoff_ff, fpoff_in;
   logic [CW-1:0]           ucount_ff, ucount_in;
   logic [10:0]             uoff_ff, uoff_in;
   logic [10:0]             ulen_ff, ulen_in;
   logic [10:0]             ioff_ff, ioff_in;

   // Unknown attribute store.
   logic [15:0]             store_ff [MAX_UNKNOWN];
   logic                    wr_en;
   logic [UIW-1:0]          wr_addr;
   logic [15:0]             wr_data;
   logic [UIW-1:0]          rd_addr;
   logic [15:0]             rd_data_ff;

   // Result side.
   stunbr_pkg::result_type  rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   stunbr_pkg::result_type  summary_ff, summary_in;
   logic                    drain_ff, drain_in;
   logic [CW-1:0]           drain_idx_ff, drain_idx_in;
   logic [CW-1:0]           drain_cnt_ff, drain_cnt_in;

   logic                    accept;
   logic                    slot_free;
   logic                    packet_end;
   stunbr_pkg::status_type  fin_status;
   stunbr_pkg::result_type  fin_summary;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !drain_ff && slot_free;
   assign accept    = req_valid && req_ready;

   // Per-byte parse.
   always_comb begin
      logic [AW-1:0] off_x;
      logic [AW-1:0] fin_x;
      logic [AW-1:0] span_x;
      logic [AW-1:0] nxt_x;
      logic [15:0]   t_x;
      logic [15:0]   len_x;
      stunbr_pkg::status_type err_x;

      pos_in      = pos_ff;
      phase_in    = phase_ff;
      shift_in    = shift_ff;
      declared_in = declared_ff;
      atype_in    = atype_ff;
      rem_in      = rem_ff;
      flags_in    = flags_ff;
      sticky_in   = sticky_ff;
      crc_in      = crc_ff;
      snap_in     = snap_ff;
      fpword_in   = fpword_ff;
      fpoff_in    = fpoff_ff;
      ucount_in   = ucount_ff;
      uoff_in     = uoff_ff;
      ulen_in     = ulen_ff;
      ioff_in     = ioff_ff;
      wr_en       = 1'b0;
      wr_addr     = ucount_ff[UIW-1:0];
      wr_data     = 16'd0;
      off_x       = AW'(pos_ff) - AW'(3);
      fin_x       = AW'(20) + AW'(declared_ff);
      t_x         = shift_in[31:16];
      len_x       = shift_in[15:0];
      span_x      = '0;
      nxt_x       = '0;
      err_x       = stunbr_pkg::ST_OK;

      if (accept && (pos_ff < PW'(MAX_BYTES))) begin
         crc_in = crc_byte(crc_ff, req_data_byte);
         pos_in = pos_ff + PW'(1);
         case (phase_ff)
            stunbr_pkg::PH_HEADER: begin
               shift_in = {shift_ff[23:0], req_data_byte};
               if (pos_ff == PW'(3)) begin
                  declared_in = shift_in[15:0];
                  atype_in    = shift_in[31:16];
               end else if (pos_ff == PW'(7)) begin
                  if (((atype_ff & stunbr_pkg::TOP_BITS) != 16'd0) ||
                      (shift_in != stunbr_pkg::COOKIE)) begin
                     sticky_in = stunbr_pkg::ST_HEADER;
                  end else if (atype_ff != stunbr_pkg::T_BINDING) begin
                     sticky_in = stunbr_pkg::ST_TYPE;
                  end
               end else if (pos_ff == PW'(19)) begin
                  if ((sticky_ff != stunbr_pkg::ST_OK) || (declared_ff == 16'd0)) begin
                     phase_in = stunbr_pkg::PH_DONE;
                  end else if (declared_ff < 16'd4) begin
                     sticky_in = stunbr_pkg::ST_TRAILING;
                     phase_in  = stunbr_pkg::PH_DONE;
                  end else begin
                     phase_in = stunbr_pkg::PH_ATTR_HDR;
                     rem_in   = 16'd4;
                  end
               end
            end
            stunbr_pkg::PH_ATTR_HDR: begin
               if ((rem_ff == 16'd4) && !flags_ff[stunbr_pkg::F_FP]) begin
                  snap_in = crc_ff;
               end
               shift_in = {shift_ff[23:0], req_data_byte};
               rem_in   = rem_ff - 16'd1;
               t_x      = shift_in[31:16];
               len_x    = shift_in[15:0];
               if (rem_ff == 16'd1) begin
                  span_x = off_x + AW'(4) + AW'(len_x);
                  if (span_x > fin_x) begin
                     err_x = stunbr_pkg::ST_OVERFLOW;
                  end else begin
                     if (!flags_ff[stunbr_pkg::F_INTEG] || (t_x == stunbr_pkg::T_FINGERPRINT)) begin
                        if (t_x == stunbr_pkg::T_USERNAME) begin
                           if (flags_ff[stunbr_pkg::F_USER]) begin
                              err_x = stunbr_pkg::ST_BAD_ATTR;
                           end else begin
                              flags_in[stunbr_pkg::F_USER] = 1'b1;
                              uoff_in = 11'(off_x + AW'(4));
                              ulen_in = len_x[10:0];
                           end
                        end else if (t_x == stunbr_pkg::T_INTEGRITY) begin
                           if ((len_x != 16'd20) || flags_ff[stunbr_pkg::F_INTEG]) begin
                              err_x = stunbr_pkg::ST_BAD_ATTR;
                           end else begin
                              flags_in[stunbr_pkg::F_INTEG] = 1'b1;
                              ioff_in = off_x[10:0];
                           end
                        end else if (t_x == stunbr_pkg::T_PRIORITY) begin
                           if ((len_x != 16'd4) || flags_ff[stunbr_pkg::F_PRIO]) begin
                              err_x = stunbr_pkg::ST_BAD_ATTR;
                           end else begin
                              flags_in[stunbr_pkg::F_PRIO] = 1'b1;
                           end
                        end else if (t_x == stunbr_pkg::T_USE_CAND) begin
                           if ((len_x != 16'd0) || flags_ff[stunbr_pkg::F_USECAND]) begin
                              err_x = stunbr_pkg::ST_BAD_ATTR;
                           end else begin
                              flags_in[stunbr_pkg::F_USECAND] = 1'b1;
                           end
                        end else if (t_x == stunbr_pkg::T_FINGERPRINT) begin
                           if ((len_x != 16'd4) || flags_ff[stunbr_pkg::F_FP]) begin
                              err_x = stunbr_pkg::ST_BAD_ATTR;
                           end else begin
                              flags_in[stunbr_pkg::F_FP] = 1'b1;
                              fpoff_in = off_x[PW-1:0];
                           end
                        end else if (t_x == stunbr_pkg::T_CONTROLLING) begin
                           if ((len_x != 16'd8) || flags_ff[stunbr_pkg::F_CTRLING]) begin
                              err_x = stunbr_pkg::ST_BAD_ATTR;
                           end else begin
                              flags_in[stunbr_pkg::F_CTRLING] = 1'b1;
                           end
                        end else if (t_x == stunbr_pkg::T_CONTROLLED) begin
                           if ((len_x != 16'd8) || flags_ff[stunbr_pkg::F_CTRLED]) begin
                              err_x = stunbr_pkg::ST_BAD_ATTR;
                           end else begin
                              flags_in[stunbr_pkg::F_CTRLED] = 1'b1;
                           end
                        end else if ((t_x < stunbr_pkg::REQUIRED_LIM) &&
                                     (t_x != stunbr_pkg::T_ERROR_CODE) &&
                                     (t_x != stunbr_pkg::T_UNKNOWN_ATT) &&
                                     (t_x != stunbr_pkg::T_XOR_MAPPED)) begin
                           if (ucount_ff < CW'(MAX_UNKNOWN)) begin
                              wr_en     = 1'b1;
                              wr_data   = t_x;
                              ucount_in = ucount_ff + CW'(1);
                           end else begin
                              flags_in[stunbr_pkg::F_UOVF] = 1'b1;
                           end
                        end
                     end
                     nxt_x = (span_x + AW'(3)) & ~AW'(3);
                     if ((err_x == stunbr_pkg::ST_OK) &&
                         ((nxt_x > fin_x) ||
                          ((fin_x != nxt_x) && ((fin_x - nxt_x) < AW'(4))))) begin
                        err_x = stunbr_pkg::ST_TRAILING;
                     end
                  end
                  if (err_x != stunbr_pkg::ST_OK) begin
                     sticky_in = err_x;
                     phase_in  = stunbr_pkg::PH_DONE;
                  end else begin
                     atype_in = t_x;
                     rem_in   = len_x;
                     if (len_x != 16'd0) begin
                        phase_in = stunbr_pkg::PH_VALUE;
                     end else begin
                        phase_in = next_phase(pos_ff, fin_x);
                        rem_in   = 16'd4;
                     end
                  end
               end
            end
            stunbr_pkg::PH_VALUE: begin
               if (atype_ff == stunbr_pkg::T_FINGERPRINT) begin
                  fpword_in = {fpword_ff[23:0], req_data_byte};
               end
               rem_in = rem_ff - 16'd1;
               if (rem_ff == 16'd1) begin
                  phase_in = next_phase(pos_ff, fin_x);
                  rem_in   = 16'd4;
               end
            end
            stunbr_pkg::PH_PAD: begin
               phase_in = next_phase(pos_ff, fin_x);
               rem_in   = 16'd4;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         pos_in = PW'(MAX_BYTES + 1);
      end

      // Final verdict of the packet, in order of precedence.
      if (pos_in > PW'(MAX_BYTES)) begin
         fin_status = stunbr_pkg::ST_TOO_LONG;
      end else if (pos_in < PW'(20)) begin
         fin_status = stunbr_pkg::ST_HEADER;
      end else if ((sticky_in == stunbr_pkg::ST_HEADER) || (sticky_in == stunbr_pkg::ST_TYPE)) begin
         fin_status = sticky_in;
      end else if (AW'(declared_in) != (AW'(pos_in) - AW'(20))) begin
         fin_status = stunbr_pkg::ST_LENGTH;
      end else if (sticky_in != stunbr_pkg::ST_OK) begin
         fin_status = sticky_in;
      end else if (!flags_in[stunbr_pkg::F_USER]) begin
         fin_status = stunbr_pkg::ST_NO_USERNAME;
      end else if (!flags_in[stunbr_pkg::F_INTEG]) begin
         fin_status = stunbr_pkg::ST_NO_INTEG;
      end else if (!flags_in[stunbr_pkg::F_FP] ||
                   ((AW'(fpoff_in) + AW'(8)) != AW'(pos_in))) begin
         fin_status = stunbr_pkg::ST_FP_PLACE;
      end else if (((~snap_in) ^ stunbr_pkg::FP_XOR) != fpword_in) begin
         fin_status = stunbr_pkg::ST_CRC;
      end else begin
         fin_status = stunbr_pkg::ST_OK;
      end

      fin_summary              = '0;
      fin_summary.kind         = 1'b1;
      fin_summary.final_result = 1'b1;
      fin_summary.status       = fin_status;
      if (fin_status == stunbr_pkg::ST_OK) begin
         fin_summary.has_priority        = flags_in[stunbr_pkg::F_PRIO];
         fin_summary.has_use_candidate   = flags_in[stunbr_pkg::F_USECAND];
         fin_summary.has_ice_controlling = flags_in[stunbr_pkg::F_CTRLING];
         fin_summary.has_ice_controlled  = flags_in[stunbr_pkg::F_CTRLED];
         fin_summary.username_offset     = uoff_in;
         fin_summary.username_length     = ulen_in;
         fin_summary.integrity_offset    = ioff_in;
         fin_summary.unknown_overflow    = flags_in[stunbr_pkg::F_UOVF];
      end

      packet_end = accept && req_last_byte;
      drain_cnt_in = ucount_in;
      if (packet_end) begin
         pos_in      = '0;
         phase_in    = stunbr_pkg::PH_HEADER;
         shift_in    = 32'd0;
         declared_in = 16'd0;
         atype_in    = 16'd0;
         rem_in      = 16'd0;
         flags_in    = 8'd0;
         sticky_in   = stunbr_pkg::ST_OK;
         crc_in      = 32'hffffffff;
         snap_in     = 32'd0;
         fpword_in   = 32'd0;
         fpoff_in    = '0;
         ucount_in   = '0;
         uoff_in     = 11'd0;
         ulen_in     = 11'd0;
         ioff_in     = 11'd0;
      end
   end

   // Result sequencing: unknown entries first, then the summary.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      summary_in   = summary_ff;
      drain_in     = drain_ff;
      drain_idx_in = drain_idx_ff;

      if (packet_end) begin
         if ((fin_status == stunbr_pkg::ST_OK) && (drain_cnt_in != '0)) begin
            drain_in     = 1'b1;
            drain_idx_in = '0;
            summary_in   = fin_summary;
         end else begin
            rsp_in       = fin_summary;
            rsp_valid_in = 1'b1;
         end
      end else if (drain_ff && slot_free) begin
         rsp_valid_in = 1'b1;
         if (drain_idx_ff < drain_cnt_ff) begin
            rsp_in                = '0;
            rsp_in.attribute_type = rd_data_ff;
            drain_idx_in          = drain_idx_ff + CW'(1);
         end else begin
            rsp_in   = summary_ff;
            drain_in = 1'b0;
         end
      end
      rd_addr = drain_idx_in[UIW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= stunbr_pkg::PH_HEADER;
         shift_ff     <= 32'd0;
         declared_ff  <= 16'd0;
         atype_ff     <= 16'd0;
         rem_ff       <= 16'd0;
         flags_ff     <= 8'd0;
         sticky_ff    <= stunbr_pkg::ST_OK;
         crc_ff       <= 32'hffffffff;
         snap_ff      <= 32'd0;
         fpword_ff    <= 32'd0;
         fpoff_ff     <= '0;
         ucount_ff    <= '0;
         uoff_ff      <= 11'd0;
         ulen_ff      <= 11'd0;
         ioff_ff      <= 11'd0;
         rsp_valid_ff <= 1'b0;
         drain_ff     <= 1'b0;
         drain_idx_ff <= '0;
         drain_cnt_ff <= '0;
      end else begin
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         declared_ff  <= declared_in;
         atype_ff     <= atype_in;
         rem_ff       <= rem_in;
         flags_ff     <= flags_in;
         sticky_ff    <= sticky_in;
         crc_ff       <= crc_in;
         snap_ff      <= snap_in;
         fpword_ff    <= fpword_in;
         fpoff_ff     <= fpoff_in;
         ucount_ff    <= ucount_in;
         uoff_ff      <= uoff_in;
         ulen_ff      <= ulen_in;
         ioff_ff      <= ioff_in;
         rsp_valid_ff <= rsp_valid_in;
         drain_ff     <= drain_in;
         drain_idx_ff <= drain_idx_in;
         if (packet_end) begin
            drain_cnt_ff <= drain_cnt_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      summary_ff <= summary_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_kind                = rsp_ff.kind;
   assign rsp_attribute_type      = rsp_ff.attribute_type;
   assign rsp_final_result        = rsp_ff.final_result;
   assign rsp_status              = rsp_ff.status;
   assign rsp_has_priority        = rsp_ff.has_priority;
   assign rsp_has_use_candidate   = rsp_ff.has_use_candidate;
   assign rsp_has_ice_controlling = rsp_ff.has_ice_controlling;
   assign rsp_has_ice_controlled  = rsp_ff.has_ice_controlled;
   assign rsp_username_offset     = rsp_ff.username_offset;
   assign rsp_username_length     = rsp_ff.username_length;
   assign rsp_integrity_offset    = rsp_ff.integrity_offset;
   assign rsp_unknown_overflow    = rsp_ff.unknown_overflow;

endmodule

`default_nettype wire

// ----- rtl/core/stunbr_checker.sv -----
// ----------------------------------------------------------------------------
// stunbr_checker
// Port-level checks on the result channel of the STUN parser.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stunbr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_kind,
   input wire logic [15:0] rsp_attribute_type,
   input wire logic        rsp_final_result,
   input wire logic [3:0]  rsp_status,
   input wire logic        rsp_has_priority,
   input wire logic        rsp_has_use_candidate,
   input wire logic        rsp_has_ice_controlling,
   input wire logic        rsp_has_ice_controlled,
   input wire logic [10:0] rsp_username_offset,
   input wire logic [10:0] rsp_username_length,
   input wire logic [10:0] rsp_integrity_offset,
   input wire logic        rsp_unknown_overflow
);

   // A stalled result keeps its contents.
   `ASSERT_CLK(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_attribute_type) && $stable(rsp_status)), "stalled result changed")

   // Unknown entries carry only their type; they are never final.
   `ASSERT_IMPLY(a_entry_clean, rsp_valid && !rsp_kind, !rsp_final_result && (rsp_status == 4'd0) && !rsp_has_priority && (rsp_username_offset == 11'd0), "unknown entry carries summary fields")

   // A summary is always the final transaction and never names a type.
   `ASSERT_IMPLY(a_summary_final, rsp_valid && rsp_kind, rsp_final_result && (rsp_attribute_type == 16'd0) && (rsp_status <= 4'd11), "summary malformed")

   // A failed packet reports no flags or positions.
   `ASSERT_IMPLY(a_fail_zero, rsp_valid && rsp_kind && (rsp_status != 4'd0), !rsp_has_priority && !rsp_has_use_candidate && !rsp_has_ice_controlling && !rsp_has_ice_controlled && (rsp_username_length == 11'd0) && (rsp_integrity_offset == 11'd0) && !rsp_unknown_overflow, "failed summary carries data")

   // While unknown entries are pending no new byte is taken.
   `ASSERT_CLK(a_entry_blocks, (rsp_valid && !rsp_kind) |-> !(req_valid && req_ready), "byte taken while entries pending")

endmodule

bind stun_binding_request_parser_top stunbr_checker u_stunbr_checker (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// STUN binding request parser testbench
// Builds STUN packets, sends them one byte per transaction and checks every
// result against a predictor that parses the same bytes.
// ----------------------------------------------------------------------------
// Well-formed binding requests with random attributes make up most of the
// traffic. A correct FINGERPRINT is computed for each of them, and some are
// then damaged. Directed packets cover each failure status, the overflow of
// the unknown attribute store and a packet longer than MAX_BYTES. Random noise
// packets are sent as well. Both sides idle at random, with calm stretches
// between. Once, the receiver holds off long enough for the input to stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import stunbr_pkg::*;

   localparam int MAXB     = 2048;
   localparam int MAXU     = 8;
   localparam int IDLE_LIM = 1500;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } wire_byte_t;

   // What goes into one generated packet.
   typedef struct {
      logic [15:0] msg_type;
      logic [31:0] cookie;
      int          n_unknown;
      bit          want_user;
      bit          want_integ;
      bit          want_fp;
      bit [3:0]    ice;
      bit          dup_user;
      bit          bad_integ_len;
      int          after_integ;
      bit          overrun;
      bit          fp_not_last;
      bit          fp_corrupt;
      int          extra_bytes;
   } recipe_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [15:0] rsp_attribute_type;
   logic        rsp_final_result;
   logic [3:0]  rsp_status;
   logic        rsp_has_priority;
   logic        rsp_has_use_candidate;
   logic        rsp_has_ice_controlling;
   logic        rsp_has_ice_controlled;
   logic [10:0] rsp_username_offset;
   logic [10:0] rsp_username_length;
   logic [10:0] rsp_integrity_offset;
   logic        rsp_unknown_overflow;

   stun_binding_request_parser_top #(.MAX_BYTES(MAXB), .MAX_UNKNOWN(MAXU)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind), .rsp_attribute_type(rsp_attribute_type),
      .rsp_final_result(rsp_final_result), .rsp_status(rsp_status),
      .rsp_has_priority(rsp_has_priority),
      .rsp_has_use_candidate(rsp_has_use_candidate),
      .rsp_has_ice_controlling(rsp_has_ice_controlling),
      .rsp_has_ice_controlled(rsp_has_ice_controlled),
      .rsp_username_offset(rsp_username_offset),
      .rsp_username_length(rsp_username_length),
      .rsp_integrity_offset(rsp_integrity_offset),
      .rsp_unknown_overflow(rsp_unknown_overflow)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Parser predictor. Its state mirrors the block's, one packet at a time.
   // ---------------------------------------------------------------------
   int unsigned pp_pos, pp_shift, pp_decl, pp_atype, pp_remain;
   int unsigned pp_sticky, pp_crc, pp_snap, pp_fpword, pp_fpoff;
   int unsigned pp_ucount;
   bit [7:0]    pp_seen;
   phase_type   pp_phase;
   logic [15:0] pp_unknown[MAXU];
   int unsigned pp_user_off, pp_user_len, pp_integ_off;

   result_type  expected_results[$];
   wire_byte_t  pending_bytes[$];

   function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
      end
      return c;
   endfunction

   task automatic parser_clear();
      pp_pos = 0; pp_phase = PH_HEADER; pp_shift = 0; pp_decl = 0;
      pp_atype = 0; pp_remain = 0; pp_seen = '0; pp_sticky = 0;
      pp_crc = 32'hffffffff; pp_snap = 0; pp_fpword = 0; pp_fpoff = 0;
      pp_ucount = 0; pp_user_off = 0; pp_user_len = 0; pp_integ_off = 0;
   endtask

   function automatic void parser_advance(int unsigned p, int unsigned stop);
      int unsigned q;
      q = p + 1;
      if ((q & 3) != 0) begin
         pp_phase = PH_PAD;
      end else if (q == stop) begin
         pp_phase = PH_DONE;
      end else begin
         pp_phase = PH_ATTR_HDR;
         pp_remain = 4;
      end
   endfunction

   // Records a known attribute, returns a bad attribute status on misuse.
   function automatic int unsigned attr_classify(logic [15:0] t, int unsigned len,
                                                int unsigned off);
      if (t == T_USERNAME) begin
         if (pp_seen[F_USER]) return ST_BAD_ATTR;
         pp_seen[F_USER] = 1'b1;
         pp_user_off = (off + 4) & 12'hfff;
         pp_user_len = len & 12'hfff;
      end else if (t == T_INTEGRITY) begin
         if (len != 20 || pp_seen[F_INTEG]) return ST_BAD_ATTR;
         pp_seen[F_INTEG] = 1'b1;
         pp_integ_off = off & 12'hfff;
      end else if (t == T_PRIORITY) begin
         if (len != 4 || pp_seen[F_PRIO]) return ST_BAD_ATTR;
         pp_seen[F_PRIO] = 1'b1;
      end else if (t == T_USE_CAND) begin
         if (len != 0 || pp_seen[F_USECAND]) return ST_BAD_ATTR;
         pp_seen[F_USECAND] = 1'b1;
      end else if (t == T_FINGERPRINT) begin
         if (len != 4 || pp_seen[F_FP]) return ST_BAD_ATTR;
         pp_seen[F_FP] = 1'b1;
         pp_fpoff = off;
      end else if (t == T_CONTROLLING) begin
         if (len != 8 || pp_seen[F_CTRLING]) return ST_BAD_ATTR;
         pp_seen[F_CTRLING] = 1'b1;
      end else if (t == T_CONTROLLED) begin
         if (len != 8 || pp_seen[F_CTRLED]) return ST_BAD_ATTR;
         pp_seen[F_CTRLED] = 1'b1;
      end else if (t < REQUIRED_LIM && t != T_ERROR_CODE && t != T_UNKNOWN_ATT &&
                   t != T_XOR_MAPPED) begin
         if (pp_ucount < MAXU) begin
            pp_unknown[pp_ucount] = t;
            pp_ucount++;
         end else begin
            pp_seen[F_UOVF] = 1'b1;
         end
      end
      return ST_OK;
   endfunction

   function automatic void parser_walk(int unsigned p, logic [7:0] b);
      int unsigned stop, off, len, err, nxt;
      logic [15:0] t;
      stop = 20 + pp_decl;
      if (pp_phase == PH_ATTR_HDR) begin
         if (pp_remain == 4 && !pp_seen[F_FP]) pp_snap = pp_crc;
         pp_shift = (pp_shift << 8) | b;
         pp_remain--;
         if (pp_remain == 0) begin
            off = p - 3;
            t = pp_shift[31:16];
            len = pp_shift[15:0];
            err = ST_OK;
            if (off + 4 + len > stop) begin
               err = ST_OVERFLOW;
            end else begin
               // Past MESSAGE-INTEGRITY only FINGERPRINT is looked at.
               if (!pp_seen[F_INTEG] || t == T_FINGERPRINT)
                  err = attr_classify(t, len, off);
               nxt = (off + 4 + len + 3) & ~32'd3;
               if (err == ST_OK && (nxt > stop || (stop - nxt != 0 && stop - nxt < 4)))
                  err = ST_TRAILING;
            end
            if (err != ST_OK) begin
               pp_sticky = err;
               pp_phase = PH_DONE;
            end else begin
               pp_atype = t;
               pp_remain = len;
               if (len > 0) pp_phase = PH_VALUE;
               else parser_advance(p, stop);
            end
         end
      end else if (pp_phase == PH_VALUE) begin
         if (pp_atype == T_FINGERPRINT) pp_fpword = (pp_fpword << 8) | b;
         pp_remain--;
         if (pp_remain == 0) parser_advance(p, stop);
      end else if (pp_phase == PH_PAD) begin
         parser_advance(p, stop);
      end
   endfunction

   function automatic void parser_header(int unsigned p, logic [7:0] b);
      pp_shift = (pp_shift << 8) | b;
      if (p == 3) begin
         pp_decl = pp_shift & 32'hffff;
         pp_atype = pp_shift >> 16;
      end else if (p == 7) begin
         if ((pp_atype & TOP_BITS) != 0 || pp_shift != COOKIE) pp_sticky = ST_HEADER;
         else if (pp_atype != T_BINDING) pp_sticky = ST_TYPE;
      end else if (p == 19) begin
         if (pp_sticky != 0 || pp_decl == 0) begin
            pp_phase = PH_DONE;
         end else if (pp_decl < 4) begin
            pp_sticky = ST_TRAILING;
            pp_phase = PH_DONE;
         end else begin
            pp_phase = PH_ATTR_HDR;
            pp_remain = 4;
         end
      end
   endfunction

   function automatic int unsigned packet_verdict(int unsigned size);
      if (size > MAXB) return ST_TOO_LONG;
      if (size < 20) return ST_HEADER;
      if (pp_sticky == ST_HEADER || pp_sticky == ST_TYPE) return pp_sticky;
      if (pp_decl != size - 20) return ST_LENGTH;
      if (pp_sticky != 0) return pp_sticky;
      if (!pp_seen[F_USER]) return ST_NO_USERNAME;
      if (!pp_seen[F_INTEG]) return ST_NO_INTEG;
      if (!pp_seen[F_FP] || pp_fpoff + 8 != size) return ST_FP_PLACE;
      if (((~pp_snap) ^ FP_XOR) != pp_fpword) return ST_CRC;
      return ST_OK;
   endfunction

   // Feeds one accepted byte to the predictor and queues what it causes.
   task automatic parse_byte(logic [7:0] b, logic last);
      int unsigned p, st;
      result_type r;
      p = pp_pos;
      if (p < MAXB) begin
         if (pp_phase == PH_HEADER) parser_header(p, b);
         else if (pp_phase != PH_DONE) parser_walk(p, b);
         pp_crc = crc32_byte(pp_crc, b);
         pp_pos = p + 1;
      end else begin
         pp_pos = MAXB + 1;
      end
      if (last) begin
         st = packet_verdict(pp_pos);
         if (st == ST_OK) begin
            for (int i = 0; i < pp_ucount; i++) begin
               r = '0;
               r.attribute_type = pp_unknown[i];
               expected_results.push_back(r);
            end
         end
         r = '0;
         r.kind = 1'b1;
         r.final_result = 1'b1;
         r.status = status_type'(st[3:0]);
         if (st == ST_OK) begin
            r.has_priority = pp_seen[F_PRIO];
            r.has_use_candidate = pp_seen[F_USECAND];
            r.has_ice_controlling = pp_seen[F_CTRLING];
            r.has_ice_controlled = pp_seen[F_CTRLED];
            r.username_offset = pp_user_off[10:0];
            r.username_length = pp_user_len[10:0];
            r.integrity_offset = pp_integ_off[10:0];
            r.unknown_overflow = pp_seen[F_UOVF];
         end
         expected_results.push_back(r);
         parser_clear();
      end
   endtask

   // ---------------------------------------------------------------------
   // Packet builder
   // ---------------------------------------------------------------------
   logic [7:0] body[$];
   int         packets_built = 0;

   task automatic put_attr(logic [15:0] t, int len);
      body.push_back(t[15:8]);
      body.push_back(t[7:0]);
      body.push_back(len[15:8]);
      body.push_back(len[7:0]);
      for (int i = 0; i < len; i++) body.push_back($urandom_range(0, 255));
      while (body.size() % 4 != 0) body.push_back($urandom_range(0, 255));
   endtask

   task automatic send_bytes(logic [7:0] pkt[$]);
      wire_byte_t w;
      foreach (pkt[i]) begin
         w.data = pkt[i];
         w.last = (i == pkt.size() - 1);
         pending_bytes.push_back(w);
      end
      packets_built++;
   endtask

   function automatic recipe_t good_recipe();
      recipe_t rc;
      rc = '{msg_type: T_BINDING, cookie: COOKIE, n_unknown: 0, want_user: 1,
             want_integ: 1, want_fp: 1, ice: 4'h0, dup_user: 0, bad_integ_len: 0,
             after_integ: 0, overrun: 0, fp_not_last: 0, fp_corrupt: 0,
             extra_bytes: 0};
      return rc;
   endfunction

   task automatic build_packet(recipe_t rc);
      logic [7:0]  pkt[$];
      logic [15:0] t, dlen;
      logic [31:0] crc, fp;
      body.delete();
      if (rc.want_user) put_attr(T_USERNAME, $urandom_range(0, 12));
      if (rc.dup_user) put_attr(T_USERNAME, $urandom_range(1, 4));
      if (rc.ice[0]) put_attr(T_PRIORITY, 4);
      for (int i = 0; i < rc.n_unknown; i++) begin
         // Mostly comprehension-required, a few optional or known types.
         case ($urandom_range(0, 5))
            0: t = 16'h8000 | 16'($urandom_range(0, 16'h7fff));
            1: t = (i % 3 == 0) ? T_ERROR_CODE : (i % 3 == 1) ? T_UNKNOWN_ATT :
                   T_XOR_MAPPED;
            default: t = 16'($urandom_range(16'h0030, 16'h7fff));
         endcase
         put_attr(t, $urandom_range(0, 8));
      end
      if (rc.ice[1]) put_attr(T_USE_CAND, 0);
      if (rc.ice[2]) put_attr(T_CONTROLLING, 8);
      if (rc.ice[3]) put_attr(T_CONTROLLED, 8);
      if (rc.want_integ) put_attr(T_INTEGRITY, rc.bad_integ_len ? 16 : 20);
      for (int i = 0; i < rc.after_integ; i++) begin
         put_attr((i == 0) ? T_PRIORITY : 16'($urandom_range(0, 16'hffff)),
                  $urandom_range(0, 8));
      end
      if (rc.overrun) begin
         body.push_back(8'h00); body.push_back(8'h31);
         body.push_back(8'h01); body.push_back(8'h00);
      end
      dlen = body.size() + (rc.want_fp ? 8 : 0) + (rc.fp_not_last ? 8 : 0);
      pkt = {rc.msg_type[15:8], rc.msg_type[7:0], dlen[15:8], dlen[7:0],
             rc.cookie[31:24], rc.cookie[23:16], rc.cookie[15:8], rc.cookie[7:0]};
      for (int i = 0; i < 12; i++) pkt.push_back($urandom_range(0, 255));
      pkt = {pkt, body};
      if (rc.want_fp) begin
         crc = 32'hffffffff;
         foreach (pkt[i]) crc = crc32_byte(crc, pkt[i]);
         fp = (~crc) ^ FP_XOR;
         if (rc.fp_corrupt) fp = fp ^ (32'h1 << $urandom_range(0, 31));
         pkt = {pkt, T_FINGERPRINT[15:8], T_FINGERPRINT[7:0], 8'h00, 8'h04,
                fp[31:24], fp[23:16], fp[15:8], fp[7:0]};
      end
      if (rc.fp_not_last) pkt = {pkt, 8'h80, 8'h30, 8'h00, 8'h04, 8'h01, 8'h02, 8'h03, 8'h04};
      for (int i = 0; i < rc.extra_bytes; i++) pkt.push_back($urandom_range(0, 255));
      send_bytes(pkt);
   endtask

   task automatic build_noise(int len, int fill);
      logic [7:0] pkt[$];
      for (int i = 0; i < len; i++)
         pkt.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
      send_bytes(pkt);
   endtask

   // Header that passes the early checks, followed by arbitrary bytes.
   task automatic build_raw_body(logic [15:0] dlen, int body_len);
      logic [7:0] pkt[$];
      pkt = {8'h00, 8'h01, dlen[15:8], dlen[7:0], 8'h21, 8'h12, 8'ha4, 8'h42};
      for (int i = 0; i < 12 + body_len; i++) pkt.push_back($urandom_range(0, 255));
      send_bytes(pkt);
   endtask

   task automatic build_directed();
      recipe_t rc;
      build_noise(1, -1);                     // single byte packet
      build_noise(19, 8'hff);                 // one byte short of a header
      rc = good_recipe(); build_packet(rc);   // minimal good request
      rc = good_recipe(); rc.ice = 4'hf; rc.n_unknown = 3; build_packet(rc);
      rc = good_recipe(); rc.n_unknown = 12; build_packet(rc);
      rc = good_recipe(); rc.cookie = 32'h2112a443; build_packet(rc);
      rc = good_recipe(); rc.msg_type = 16'h0101; build_packet(rc);
      rc = good_recipe(); rc.msg_type = 16'hc001; build_packet(rc);
      rc = good_recipe(); rc.extra_bytes = 4; build_packet(rc);
      build_raw_body(16'h0000, 0);            // empty body
      build_raw_body(16'h0002, 2);            // body too short for an attribute
      rc = good_recipe(); rc.dup_user = 1; build_packet(rc);
      rc = good_recipe(); rc.bad_integ_len = 1; build_packet(rc);
      rc = good_recipe(); rc.want_fp = 0; rc.overrun = 1; build_packet(rc);
      rc = good_recipe(); rc.want_user = 0; build_packet(rc);
      rc = good_recipe(); rc.want_integ = 0; build_packet(rc);
      rc = good_recipe(); rc.want_fp = 0; build_packet(rc);
      rc = good_recipe(); rc.fp_not_last = 1; build_packet(rc);
      rc = good_recipe(); rc.fp_corrupt = 1; build_packet(rc);
      rc = good_recipe(); rc.after_integ = 2; build_packet(rc);
      build_raw_body(16'h0800, MAXB + 40);    // longer than the block takes
   endtask

   task automatic build_random();
      recipe_t    rc;
      int         sel;
      logic [7:0] pkt[$];
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         build_noise($urandom_range(1, 40), -1);
      end else begin
         rc = good_recipe();
         rc.ice = $urandom_range(0, 15);
         rc.n_unknown = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 11)
                                                     : $urandom_range(0, 3);
         rc.want_user = ($urandom_range(0, 19) != 0);
         rc.want_integ = ($urandom_range(0, 19) != 0);
         rc.want_fp = ($urandom_range(0, 19) != 0);
         rc.after_integ = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
         if (sel < 25) begin
            // Broken request: one fault picked at random.
            case ($urandom_range(0, 6))
               0: rc.dup_user = 1;
               1: rc.bad_integ_len = 1;
               2: rc.overrun = 1;
               3: rc.fp_not_last = 1;
               4: rc.fp_corrupt = 1;
               5: rc.extra_bytes = $urandom_range(1, 6);
               default: rc.msg_type = 16'($urandom_range(0, 16'hffff));
            endcase
         end
         build_packet(rc);
         if (sel >= 25 && sel < 32) begin
            // Flip one bit of the packet just queued.
            sel = pending_bytes.size() - 1 - $urandom_range(0, 40);
            if (sel >= 0)
               pending_bytes[sel].data = pending_bytes[sel].data ^ (8'h1 << $urandom_range(0, 7));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver, receiver and checker
   // ---------------------------------------------------------------------
   int  send_gap = 0, recv_stall = 0, cycle_count = 0, results_seen = 0;
   int  mismatches = 0, idle_cycles = 0;
   bit  byte_taken = 1'b0, hold_off = 1'b0;
   wire calm = (cycle_count % 700) < 150;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      wire_byte_t w;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            w = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= w.data;
            req_last_byte <= w.last;
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
      if (reset || hold_off) begin
         rsp_ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         recv_stall <= pick_gap();
      end
   end

   // Long hold-off on the result side; the sender keeps offering meanwhile,
   // so the block fills up and lowers req_ready.
   initial begin
      wait (results_seen >= 12);
      @(negedge clock);
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      @(negedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      result_type got, exp;
      bit         req_fire, rsp_fire;
      req_fire = !reset && req_valid && req_ready;
      rsp_fire = !reset && rsp_valid && rsp_ready;
      byte_taken <= req_fire;
      if (req_fire) parse_byte(req_data_byte, req_last_byte);
      if (rsp_fire) begin
         got = '0;
         got.kind = rsp_kind;
         got.attribute_type = rsp_attribute_type;
         got.final_result = rsp_final_result;
         got.status = status_type'(rsp_status);
         got.has_priority = rsp_has_priority;
         got.has_use_candidate = rsp_has_use_candidate;
         got.has_ice_controlling = rsp_has_ice_controlling;
         got.has_ice_controlled = rsp_has_ice_controlled;
         got.username_offset = rsp_username_offset;
         got.username_length = rsp_username_length;
         got.integrity_offset = rsp_integrity_offset;
         got.unknown_overflow = rsp_unknown_overflow;
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("unexpected result transaction: kind %0d type %h status %0d",
                        got.kind, got.attribute_type, got.status);
         end else begin
            exp = expected_results.pop_front();
            if (got.kind !== exp.kind || got.attribute_type !== exp.attribute_type ||
                got.final_result !== exp.final_result || got.status !== exp.status ||
                got.has_priority !== exp.has_priority ||
                got.has_use_candidate !== exp.has_use_candidate ||
                got.has_ice_controlling !== exp.has_ice_controlling ||
                got.has_ice_controlled !== exp.has_ice_controlled ||
                got.username_offset !== exp.username_offset ||
                got.username_length !== exp.username_length ||
                got.integrity_offset !== exp.integrity_offset ||
                got.unknown_overflow !== exp.unknown_overflow) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) begin
                  $display("mismatch: expected kind %0d type %h fin %0d st %0d ice %b%b%b%b",
                           exp.kind, exp.attribute_type, exp.final_result, exp.status,
                           exp.has_priority, exp.has_use_candidate,
                           exp.has_ice_controlling, exp.has_ice_controlled);
                  $display("          user %0d/%0d integ %0d ovf %0d", exp.username_offset,
                           exp.username_length, exp.integrity_offset, exp.unknown_overflow);
                  $display("  actual: kind %0d type %h fin %0d st %0d ice %b%b%b%b",
                           got.kind, got.attribute_type, got.final_result, got.status,
                           got.has_priority, got.has_use_candidate,
                           got.has_ice_controlling, got.has_ice_controlled);
                  $display("          user %0d/%0d integ %0d ovf %0d", got.username_offset,
                           got.username_length, got.integrity_offset, got.unknown_overflow);
               end
            end
         end
      end
      // Watchdog: cycles in which neither side completes a transaction.
      if (reset || req_fire || rsp_fire) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIM) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIM);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      parser_clear();
      build_directed();
      while (packets_built < 70 || pending_bytes.size() < 380) build_random();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_bytes.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
